@@ hdl/gbe_pkg.sv @@
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and codes for the banked GPIO edge-interrupt register block.
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int unsigned WordW = 32;

  // Operation codes carried by an input beat
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_IDLE  = 2'd3
  } op_e;

  // Register map
  typedef enum logic [3:0] {
    REG_DIR     = 4'd0,
    REG_OUT     = 4'd1,
    REG_SET     = 4'd2,
    REG_CLR     = 4'd3,
    REG_IN      = 4'd4,
    REG_SETRIS  = 4'd5,
    REG_CLRRIS  = 4'd6,
    REG_SETFAL  = 4'd7,
    REG_CLRFAL  = 4'd8,
    REG_STATUS  = 4'd9,
    REG_BANK_EN = 4'd10
  } reg_e;

  // What the back end has to do with a queued command
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_kind_e;

  // Classified command passed from front end to back end
  typedef struct packed {
    cmd_kind_e        kind;
    reg_e             sel;
    logic             bad;
    logic [WordW-1:0] data;  // write word, or pin levels on a tick
  } cmd_t;

endpackage

@@ hdl/gbe_front.sv @@
// ----------------------------------------------------------------------------
// gbe_front
// Front end: classifies an incoming beat into a command for the back end.
// ----------------------------------------------------------------------------
module gbe_front (
  input  logic [1:0]         op_i,
  input  logic [3:0]         reg_index_i,
  input  logic [31:0]        write_data_i,
  input  logic [31:0]        pin_levels_i,
  output gbe_pkg::cmd_t      cmd_o
);
  import gbe_pkg::*;

  logic reg_known;

  assign reg_known = (reg_index_i <= REG_BANK_EN);

  // Decode operation and register index
  always_comb begin
    cmd_o.kind = CMD_NOP;
    cmd_o.sel  = REG_DIR;
    cmd_o.bad  = 1'b0;
    cmd_o.data = write_data_i;
    unique case (op_e'(op_i))
      OP_READ: begin
        if (reg_known) begin
          cmd_o.kind = CMD_READ;
          cmd_o.sel  = reg_e'(reg_index_i);
        end else begin
          cmd_o.bad = 1'b1;
        end
      end
      OP_WRITE: begin
        if (reg_known && (reg_e'(reg_index_i) != REG_IN)) begin
          cmd_o.kind = CMD_WRITE;
          cmd_o.sel  = reg_e'(reg_index_i);
        end else begin
          cmd_o.bad = 1'b1;
        end
      end
      OP_TICK: begin
        cmd_o.kind = CMD_TICK;
        cmd_o.data = pin_levels_i;
      end
      OP_IDLE: begin
        cmd_o.kind = CMD_NOP;
      end
      default: begin
        cmd_o.kind = CMD_NOP;
      end
    endcase
  end

endmodule

@@ hdl/gbe_queue.sv @@
// ----------------------------------------------------------------------------
// gbe_queue
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module gbe_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  gbe_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output gbe_pkg::cmd_t pop_cmd_o
);
  import gbe_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t            slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed command
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ hdl/gbe_back.sv @@
// ----------------------------------------------------------------------------
// gbe_back
// Back end: executes commands on the register file and holds the result beat.
// ----------------------------------------------------------------------------
module gbe_back #(
  parameter int unsigned BANK_PINS  = 16,
  parameter int unsigned BANK_COUNT = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  gbe_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   read_data_o,
  output logic [31:0]   pin_drive_o,
  output logic [31:0]   pin_direction_o,
  output logic [1:0]    bank_irq_o,
  output logic          bad_access_o
);
  import gbe_pkg::*;

  localparam int unsigned TotalPins = BANK_PINS * BANK_COUNT;
  localparam logic [WordW-1:0] PinsMask =
    (TotalPins >= WordW) ? '1 : ((WordW'(1) << TotalPins) - WordW'(1));
  localparam logic [WordW-1:0] BankWidthMask =
    (BANK_PINS >= WordW) ? '1 : ((WordW'(1) << BANK_PINS) - WordW'(1));
  localparam logic [WordW-1:0] Bank0Mask = BankWidthMask & PinsMask;
  localparam logic [WordW-1:0] Bank1Mask =
    ((BANK_COUNT < 2) || (BANK_PINS >= WordW)) ? '0 :
    ((BankWidthMask << BANK_PINS) & PinsMask);

  logic [WordW-1:0]      dir_q, dir_d;
  logic [WordW-1:0]      out_q, out_d;
  logic [WordW-1:0]      in_q, in_d;
  logic [WordW-1:0]      rise_q, rise_d;
  logic [WordW-1:0]      fall_q, fall_d;
  logic [WordW-1:0]      pend_q, pend_d;
  logic [BANK_COUNT-1:0] ben_q, ben_d;
  logic [BANK_COUNT:0]   ben_pad;
  logic [WordW-1:0]      data_m;
  logic [WordW-1:0]      rd;
  logic [1:0]            irq;
  logic                  out_valid_q;
  logic                  take;

  // Take a command when the result slot is free or draining
  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign data_m      = cmd_i.data & PinsMask;

  // Next register state and read word
  always_comb begin
    dir_d  = dir_q;
    out_d  = out_q;
    in_d   = in_q;
    rise_d = rise_q;
    fall_d = fall_q;
    pend_d = pend_q;
    ben_d  = ben_q;
    rd     = '0;
    case (cmd_i.kind)
      CMD_READ: begin
        case (cmd_i.sel) inside
          REG_DIR:                   rd = dir_q;
          REG_OUT, REG_SET, REG_CLR: rd = out_q;
          REG_IN:                    rd = in_q;
          REG_SETRIS, REG_CLRRIS:    rd = rise_q;
          REG_SETFAL, REG_CLRFAL:    rd = fall_q;
          REG_STATUS:                rd = pend_q;
          REG_BANK_EN:               rd = WordW'(ben_q);
          default:                   rd = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (cmd_i.sel)
          REG_DIR:     dir_d  = data_m;
          REG_OUT:     out_d  = data_m;
          REG_SET:     out_d  = out_q | data_m;
          REG_CLR:     out_d  = out_q & ~data_m;
          REG_SETRIS:  rise_d = rise_q | data_m;
          REG_CLRRIS:  rise_d = rise_q & ~data_m;
          REG_SETFAL:  fall_d = fall_q | data_m;
          REG_CLRFAL:  fall_d = fall_q & ~data_m;
          REG_STATUS:  pend_d = pend_q & ~data_m;
          REG_BANK_EN: ben_d  = cmd_i.data[BANK_COUNT-1:0];
          default:     dir_d  = dir_q;
        endcase
      end
      CMD_TICK: begin
        // latch pins; enabled edges raise status
        pend_d = (pend_q | (~in_q & data_m & rise_q) | (in_q & ~data_m & fall_q))
                 & PinsMask;
        in_d   = data_m;
      end
      default: begin
        rd = '0;
      end
    endcase
  end

  // Per-bank interrupt lines from the updated state
  assign ben_pad = {1'b0, ben_d};
  assign irq[0]  = ben_pad[0] && ((pend_d & Bank0Mask) != '0);
  assign irq[1]  = ben_pad[1] && ((pend_d & Bank1Mask) != '0);

  // Hold register file and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= PinsMask;
      out_q       <= '0;
      in_q        <= '0;
      rise_q      <= '0;
      fall_q      <= '0;
      pend_q      <= '0;
      ben_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        dir_q  <= dir_d;
        out_q  <= out_d;
        in_q   <= in_d;
        rise_q <= rise_d;
        fall_q <= fall_d;
        pend_q <= pend_d;
        ben_q  <= ben_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load result beat payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      read_data_o     <= rd;
      pin_drive_o     <= out_d;
      pin_direction_o <= dir_d;
      bank_irq_o      <= irq;
      bad_access_o    <= cmd_i.bad;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/banked_gpio_edge_irq_regs.sv @@
// ----------------------------------------------------------------------------
// banked_gpio_edge_irq_regs
// GPIO register block with two pin banks and edge-triggered interrupts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per bus read,
//   bus write or pin-sample tick, selected by op_i. Output channel
//   (out_valid_o / out_ready_i) returns exactly one result beat per input
//   beat, in order: read data, output latch, direction, per-bank interrupt
//   lines and an access error flag, all as they stand after that beat.
//   Timing: out_valid_o rises once the beat has passed the queue write and
//   then the result register write. With the receiver ready, throughput is
//   one beat per cycle; the back end updates all registers when it takes a
//   command, so the result register is the only pacing element.
//   When the receiver stalls the result beat holds, the back end stops
//   draining the queue, and in_ready_o drops once both queue entries fill.
//   Reset empties the queue and the result slot, sets every pin to input and
//   clears output data, edge enables, status and bank enables.
// ----------------------------------------------------------------------------
module banked_gpio_edge_irq_regs #(
  parameter int unsigned BANK_PINS  = 16,
  parameter int unsigned BANK_COUNT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [31:0] pin_drive_o,
  output logic [31:0] pin_direction_o,
  output logic [1:0]  bank_irq_o,
  output logic        bad_access_o
);
  import gbe_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  // Classify incoming beat
  gbe_front u_front (
    .op_i         (op_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .pin_levels_i (pin_levels_i),
    .cmd_o        (front_cmd)
  );

  // Decouple front and back
  gbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  // Execute on register file
  gbe_back #(
    .BANK_PINS  (BANK_PINS),
    .BANK_COUNT (BANK_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (back_valid),
    .cmd_ready_o     (back_ready),
    .cmd_i           (back_cmd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .read_data_o     (read_data_o),
    .pin_drive_o     (pin_drive_o),
    .pin_direction_o (pin_direction_o),
    .bank_irq_o      (bank_irq_o),
    .bad_access_o    (bad_access_o)
  );

endmodule

@@ hdl/gbe_checker.sv @@
// ----------------------------------------------------------------------------
// gbe_checker
// Port-level checks for the banked GPIO register block, bound to the top.
// ----------------------------------------------------------------------------
module gbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_data_o,
  input logic [31:0] pin_drive_o,
  input logic [31:0] pin_direction_o,
  input logic [1:0]  bank_irq_o,
  input logic        bad_access_o
);

  // Result beat stays up until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(read_data_o) && $stable(pin_drive_o) && $stable(pin_direction_o)
      && $stable(bank_irq_o) && $stable(bad_access_o))
    else $error("stalled result beat changed");

  // Bad access never returns read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_access_o |-> (read_data_o == '0))
    else $error("bad access returned data");

  // Empty result slot implies the queue can take a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result slot");

  // A beat accepted into an empty pipe shows once it has passed the queue and the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 (out_valid_o || $past(out_valid_o)))
    else $error("accepted beat lost");

endmodule

bind banked_gpio_edge_irq_regs gbe_checker u_gbe_checker (.*);
